@@ hw/rtl/moving_average_window_indicator_defines.svh @@
// ----------------------------------------------------------------------------
// Moving average window indicator: assertion macros
// Shared concurrent assertion forms used by the indicator's RTL modules.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_WINDOW_INDICATOR_DEFINES_SVH
`define MOVING_AVERAGE_WINDOW_INDICATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAWI_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MAWI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mawi_pkg.sv @@
// ----------------------------------------------------------------------------
// Moving average window indicator package
// Field widths, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mawi_pkg;

    // Width of a converter sample, of the average and of both thresholds.
    localparam int SAMPLE_W = 10;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Default number of samples in the averaging window.
    localparam int WINDOW_DEFAULT = 10;

    // Threshold reset values.
    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RESET = 10'd767;
    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RESET  = 10'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd1;

    typedef logic [SAMPLE_W-1:0]  sample_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Both thresholds, as handed from the register file to the compare stage.
    typedef struct packed {
        sample_t high;
        sample_t low;
    } thresh_t;

endpackage

`default_nettype wire

@@ hw/rtl/mawi_in_if.sv @@
// ----------------------------------------------------------------------------
// Sample channel
// Carries one converter sample and the mode switch level per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mawi_in_if import mawi_pkg::*; ();

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    mode_switch;

    modport source (output valid, output sample, output mode_switch, input ready);
    modport sink   (input valid, input sample, input mode_switch, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/mawi_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Carries the window average and both indicator levels per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mawi_out_if import mawi_pkg::*; ();

    logic    valid;
    logic    ready;
    sample_t average;
    logic    red_on;
    logic    blue_on;

    modport source (output valid, output average, output red_on, output blue_on,
                    input ready);
    modport sink   (input valid, input average, input red_on, input blue_on,
                    output ready);

endinterface

`default_nettype wire

@@ hw/rtl/mawi_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data written to it per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mawi_cfg_if import mawi_pkg::*; ();

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    sample_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/moving_average_window_indicator.sv @@
// ----------------------------------------------------------------------------
// Moving average window indicator
// Averages the last WINDOW converter samples and drives red and blue lights.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock while the result channel is not
// stalled, and returns one result word per sample. On acceptance the sample
// replaces the oldest entry of the window ring and the running sum register
// is updated; once the result register is free, the sum is divided by WINDOW
// and compared with the thresholds into the result register. The running sum
// update sustains one word per cycle. After reset the ring reads as all zero,
// so early averages count the missing samples as zero. Thresholds are written
// through the configuration channel, which is always ready; the user must
// write them only while no sample is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "moving_average_window_indicator_defines.svh"

module moving_average_window_indicator import mawi_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    mawi_in_if.sink    sample_ch,
    mawi_out_if.source result_ch,
    mawi_cfg_if.sink   cfg_ch
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

    logic             stage_valid_reg;
    logic             stage_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             mode_reg;
    logic             in_ready;
    logic             accept;
    logic             out_load;
    logic [SUM_W-1:0] sum;
    thresh_t          thresh;

    // Handshake: the sum stage moves on when the result register is free.
    assign out_load = stage_valid_reg && (!out_valid_reg || result_ch.ready);
    assign in_ready = !stage_valid_reg || out_load;
    assign accept   = sample_ch.valid && in_ready;

    assign stage_valid_next = accept ? 1'b1 : (out_load ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = out_load ? 1'b1 :
                              (result_ch.ready ? 1'b0 : out_valid_reg);

    // Stage and result valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Mode switch travels alongside the running sum.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= sample_ch.mode_switch;
        end
    end

    // Threshold registers.
    mawi_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_ch.valid),
        .wr_index (cfg_ch.index),
        .wr_data  (cfg_ch.data),
        .thresh   (thresh)
    );

    // Window ring and running sum.
    mawi_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample_ch.sample),
        .sum    (sum)
    );

    // Average, compare and result register.
    mawi_result #(
        .WINDOW (WINDOW)
    ) u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .sum         (sum),
        .mode_switch (mode_reg),
        .thresh      (thresh),
        .average     (result_ch.average),
        .red_on      (result_ch.red_on),
        .blue_on     (result_ch.blue_on)
    );

    assign sample_ch.ready = in_ready;
    assign result_ch.valid = out_valid_reg;
    assign cfg_ch.ready    = 1'b1;

    `MAWI_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
        stage_valid_reg && out_valid_reg && !result_ch.ready, !sample_ch.ready,
        "sample taken while the sum stage was blocked")
    `MAWI_ASSERT_NEXT(a_load_shows_result, clk, rst_n, out_load, result_ch.valid,
        "loaded result word not presented")

endmodule

`default_nettype wire

@@ hw/rtl/mawi_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Threshold register file
// Holds the high and low thresholds, written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module mawi_cfg_regs import mawi_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  cfg_idx_t wr_index,
    input  sample_t  wr_data,
    output thresh_t  thresh
);

    sample_t high_reg;
    sample_t high_next;
    sample_t low_reg;
    sample_t low_next;

    // Write decode; an index beyond the register list changes nothing.
    always_comb
    begin
        high_next = high_reg;
        low_next  = low_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_HIGH_THRESHOLD: high_next = wr_data;
                CFG_LOW_THRESHOLD:  low_next  = wr_data;
                default:
                begin
                    high_next = high_reg;
                    low_next  = low_reg;
                end
            endcase
        end
    end

    // Threshold registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= HIGH_THRESHOLD_RESET;
            low_reg  <= LOW_THRESHOLD_RESET;
        end
        else
        begin
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    assign thresh.high = high_reg;
    assign thresh.low  = low_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mawi_accum.sv @@
// ----------------------------------------------------------------------------
// Sample ring and running sum
// Replaces the oldest sample of the window and keeps the window sum current.
// ----------------------------------------------------------------------------
`default_nettype none
`include "moving_average_window_indicator_defines.svh"

module mawi_accum import mawi_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  sample_t                                sample,
    output logic [SAMPLE_W+$clog2(WINDOW)-1:0]     sum
);

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    sample_t           ring_reg [WINDOW];
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    sample_t           oldest;

    // The entry about to be overwritten leaves the sum as the new one enters.
    assign oldest    = ring_reg[slot_reg];
    assign sum_next  = sum_reg - SUM_W'(oldest) + SUM_W'(sample);
    assign slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);

    // Ring, write pointer and sum; the whole window reads as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            slot_reg <= '0;
            sum_reg  <= '0;
        end
        else if (accept)
        begin
            ring_reg[slot_reg] <= sample;
            slot_reg           <= slot_next;
            sum_reg            <= sum_next;
        end
    end

    assign sum = sum_reg;

    `MAWI_ASSERT_NOW(a_slot_range, clk, rst_n, 1'b1, slot_reg <= LAST_SLOT,
        "write pointer left the window")
    `MAWI_ASSERT_NEXT(a_slot_step, clk, rst_n, accept && (slot_reg != LAST_SLOT),
        slot_reg == $past(slot_reg) + SLOT_W'(1), "write pointer did not advance")
    `MAWI_ASSERT_NEXT(a_slot_wrap, clk, rst_n, accept && (slot_reg == LAST_SLOT),
        slot_reg == '0, "write pointer did not wrap to the first entry")

endmodule

`default_nettype wire

@@ hw/rtl/mawi_result.sv @@
// ----------------------------------------------------------------------------
// Average and window compare
// Divides the window sum by the window length and drives both indicators.
// ----------------------------------------------------------------------------
`default_nettype none
`include "moving_average_window_indicator_defines.svh"

module mawi_result import mawi_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [SAMPLE_W+$clog2(WINDOW)-1:0] sum,
    input  logic                               mode_switch,
    input  thresh_t                            thresh,
    output sample_t                            average,
    output logic                               red_on,
    output logic                               blue_on
);

    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW);
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = RECIP_SHIFT + SAMPLE_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW);

    logic [PROD_W-1:0] product;
    sample_t           avg_next;
    logic              red_next;
    logic              blue_next;
    sample_t           avg_reg;
    logic              red_reg;
    logic              blue_reg;

    // Truncated mean by reciprocal multiplication. The reciprocal is rounded up
    // at a scale of the sum width plus the window's bit count, which makes the
    // quotient exact for every sum the window can hold; the mean fits the top
    // SAMPLE_W bits of the product.
    assign product  = PROD_W'(sum) * PROD_W'(RECIP);
    assign avg_next = product[PROD_W-1 -: SAMPLE_W];

    // Red wins when the thresholds cross; the switch low lights both.
    always_comb
    begin
        if (!mode_switch)
        begin
            red_next  = 1'b1;
            blue_next = 1'b1;
        end
        else if (avg_next > thresh.high)
        begin
            red_next  = 1'b1;
            blue_next = 1'b0;
        end
        else if (avg_next < thresh.low)
        begin
            red_next  = 1'b0;
            blue_next = 1'b1;
        end
        else
        begin
            red_next  = 1'b0;
            blue_next = 1'b0;
        end
    end

    // Result register; the handshake valid lives in the top level.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            avg_reg  <= avg_next;
            red_reg  <= red_next;
            blue_reg <= blue_next;
        end
    end

    assign average = avg_reg;
    assign red_on  = red_reg;
    assign blue_on = blue_reg;

    `MAWI_ASSERT_NEXT(a_forced_lights, clk, rst_n, load && !mode_switch,
        red_on && blue_on, "switch low did not light both indicators")
    `MAWI_ASSERT_NEXT(a_exclusive_lights, clk, rst_n, load && mode_switch,
        !(red_on && blue_on), "window compare lit both indicators")

endmodule

`default_nettype wire

@@ tb/moving_average_window_indicator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average window indicator testbench
// Drives sample words and threshold writes into the indicator and checks
// every result word against its typed value or an in-bench model of the
// window ring, the running sum and the light decision. A short table of
// directed words comes first, then level-tracking random runs under several
// threshold settings and three idle patterns, with one long result stall.
// ----------------------------------------------------------------------------

module moving_average_window_indicator_tb;
    import mawi_pkg::*;

    localparam int      WINDOW       = 10;
    localparam sample_t SAMPLE_MAX   = 10'd1023;
    localparam int      RANDOM_WORDS = 56;
    localparam int      HOLD_CYCLES  = 120;
    localparam int      DRAIN_CYCLES = 4;

    // Register indexes that map to no register; writes to them must be ignored.
    localparam cfg_idx_t CFG_SPARE_A = 2'd2;
    localparam cfg_idx_t CFG_SPARE_B = 2'd3;

    typedef struct packed {
        sample_t average;
        logic    red_on;
        logic    blue_on;
    } light_word_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_idx_t    idx;
        sample_t     value;
        logic        mode;
        logic        typed;
        light_word_t want;
    } plan_row_t;

    typedef enum logic [2:0] {
        RUN_NEAR,
        RUN_FLAT_HIGH,
        RUN_FLAT_LOW,
        RUN_EDGE,
        RUN_NOISE
    } run_kind_t;

    logic clk;
    logic rst_n;

    mawi_in_if  sample_bus ();
    mawi_out_if result_bus ();
    mawi_cfg_if cfg_bus ();

    moving_average_window_indicator #(
        .WINDOW (WINDOW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_bus),
        .result_ch (result_bus),
        .cfg_ch    (cfg_bus)
    );

    // Model state of the window and the thresholds.
    sample_t     win_ring [WINDOW];
    logic [3:0]  win_slot;
    logic [13:0] win_sum;
    sample_t     high_thr;
    sample_t     low_thr;

    // Expected result words, oldest first.
    light_word_t light_q [$];
    plan_row_t   plan [$];

    int mismatch_cnt  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;

    // Random run state for the sample generator.
    run_kind_t run_kind = RUN_NOISE;
    int        run_left = 0;
    int        level    = 0;
    int        spread   = 0;

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Advance the window by one sample and work out the result word.
    task automatic window_predict(input sample_t s, input logic m, output light_word_t r);
        sample_t avg;
        win_sum            = win_sum - win_ring[win_slot] + s;
        win_ring[win_slot] = s;
        win_slot           = (win_slot == WINDOW - 1) ? 4'd0 : win_slot + 4'd1;
        avg                = sample_t'(win_sum / WINDOW);
        r.average          = avg;
        if (!m)
        begin
            r.red_on  = 1'b1;
            r.blue_on = 1'b1;
        end
        else if (avg > high_thr)
        begin
            r.red_on  = 1'b1;
            r.blue_on = 1'b0;
        end
        else if (avg < low_thr)
        begin
            r.red_on  = 1'b0;
            r.blue_on = 1'b1;
        end
        else
        begin
            r.red_on  = 1'b0;
            r.blue_on = 1'b0;
        end
    endtask

    // Offer one sample word, with random idle cycles ahead of it.
    task automatic send_word(input sample_t s, input logic m, input logic typed,
                             input light_word_t want);
        light_word_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.sample      <= s;
        sample_bus.mode_switch <= m;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        window_predict(s, m, pred);
        light_q.push_back(typed ? want : pred);
    endtask

    // Write a register once the block has drained.
    task automatic write_reg(input cfg_idx_t idx, input sample_t data);
        sample_bus.valid <= 1'b0;
        while (light_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_HIGH_THRESHOLD: high_thr = data;
            CFG_LOW_THRESHOLD:  low_thr  = data;
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic add_word(input sample_t s, input logic m, input logic typed,
                            input light_word_t want);
        plan_row_t row;
        row.kind  = ROW_WORD;
        row.idx   = CFG_HIGH_THRESHOLD;
        row.value = s;
        row.mode  = m;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    task automatic add_reg(input cfg_idx_t idx, input sample_t data);
        plan_row_t row;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.value = data;
        row.mode  = 1'b0;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endtask

    // Samples come in runs: near a level, flat on a threshold, at the rails,
    // or plain noise, so that the average sweeps the range and sits exactly
    // on the thresholds now and then.
    task automatic draw_sample(output sample_t s);
        int v;
        int pick;
        if (run_left == 0)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                run_kind = RUN_NEAR;
                level    = $urandom_range(1023);
                spread   = $urandom_range(63);
                run_left = $urandom_range(20, 4);
            end
            else if (pick < 50)
            begin
                run_kind = RUN_FLAT_HIGH;
                run_left = $urandom_range(2 * WINDOW, WINDOW);
            end
            else if (pick < 65)
            begin
                run_kind = RUN_FLAT_LOW;
                run_left = $urandom_range(2 * WINDOW, WINDOW);
            end
            else if (pick < 80)
            begin
                run_kind = RUN_EDGE;
                run_left = $urandom_range(16, 4);
            end
            else
            begin
                run_kind = RUN_NOISE;
                run_left = $urandom_range(8, 1);
            end
        end
        run_left = run_left - 1;
        case (run_kind)
            RUN_NEAR:
            begin
                v = level + int'($urandom_range(2 * spread)) - spread;
                if (v < 0)
                    v = 0;
                if (v > int'(SAMPLE_MAX))
                    v = int'(SAMPLE_MAX);
            end
            RUN_FLAT_HIGH: v = int'(high_thr);
            RUN_FLAT_LOW:  v = int'(low_thr);
            RUN_EDGE:      v = $urandom_range(1) ? int'(SAMPLE_MAX) : 0;
            default:       v = $urandom_range(1023);
        endcase
        s = sample_t'(v);
    endtask

    // Result side: check each accepted word and drive ready.
    initial
    begin : result_side
        light_word_t want;
        int          hold_seen;
        int          hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (light_q.size() == 0)
                begin
                    $error("result word with no expectation: average %0d red %0b blue %0b",
                           result_bus.average, result_bus.red_on, result_bus.blue_on);
                    mismatch_cnt++;
                end
                else
                begin
                    want = light_q.pop_front();
                    if (result_bus.average !== want.average)
                    begin
                        $error("average: expected %0d, got %0d",
                               want.average, result_bus.average);
                        mismatch_cnt++;
                    end
                    if (result_bus.red_on !== want.red_on)
                    begin
                        $error("red_on: expected %0b, got %0b", want.red_on, result_bus.red_on);
                        mismatch_cnt++;
                    end
                    if (result_bus.blue_on !== want.blue_on)
                    begin
                        $error("blue_on: expected %0b, got %0b",
                               want.blue_on, result_bus.blue_on);
                        mismatch_cnt++;
                    end
                end
            end
            // A long hold-off lets the block fill up and stall its input.
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus.
    initial
    begin : stimulus
        sample_t     s;
        sample_t     hi;
        sample_t     lo;
        logic        m;
        int          i;
        int          pass_i;
        int          k;
        plan_row_t   row;

        rst_n                  <= 1'b0;
        sample_bus.valid       <= 1'b0;
        sample_bus.sample      <= '0;
        sample_bus.mode_switch <= 1'b0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.index          <= CFG_HIGH_THRESHOLD;
        cfg_bus.data           <= '0;

        for (i = 0; i < WINDOW; i++)
            win_ring[i] = '0;
        win_slot = '0;
        win_sum  = '0;
        high_thr = HIGH_THRESHOLD_RESET;
        low_thr  = LOW_THRESHOLD_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed words are {average, red_on, blue_on}.
        // Fresh ring at reset thresholds: zero average is blue only.
        add_word('0, 1'b1, 1'b1, {10'd0, 1'b0, 1'b1});
        // Fill the ring at full scale; the last one lands in slot zero after the wrap.
        for (i = 0; i < WINDOW - 1; i++)
            add_word(SAMPLE_MAX, 1'b1, 1'b0, '0);
        add_word(SAMPLE_MAX, 1'b1, 1'b1, {SAMPLE_MAX, 1'b1, 1'b0});
        // Switch low forces both lights.
        add_word(SAMPLE_MAX, 1'b0, 1'b1, {SAMPLE_MAX, 1'b1, 1'b1});
        // Average equal to the high threshold does not light red.
        add_reg(CFG_HIGH_THRESHOLD, SAMPLE_MAX);
        add_reg(CFG_LOW_THRESHOLD, '0);
        add_word(SAMPLE_MAX, 1'b1, 1'b1, {SAMPLE_MAX, 1'b0, 1'b0});
        // Crossed thresholds: red test wins.
        add_reg(CFG_HIGH_THRESHOLD, '0);
        add_reg(CFG_LOW_THRESHOLD, SAMPLE_MAX);
        add_word(SAMPLE_MAX, 1'b1, 1'b1, {SAMPLE_MAX, 1'b1, 1'b0});
        // Drain the ring back to zero under crossed thresholds.
        for (i = 0; i < WINDOW - 1; i++)
            add_word('0, 1'b1, 1'b0, '0);
        add_word('0, 1'b1, 1'b1, {10'd0, 1'b0, 1'b1});
        add_word('0, 1'b0, 1'b1, {10'd0, 1'b1, 1'b1});

        send_idle_pct = 31;
        recv_idle_pct = 85;
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_REG)
                write_reg(row.idx, row.value);
            else
                send_word(row.value, row.mode, row.typed, row.want);
        end

        // Random part: three idle patterns, three threshold settings each.
        for (pass_i = 0; pass_i < 3; pass_i++)
        begin
            case (pass_i)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (k = 0; k < 3; k++)
            begin
                case (k)
                    0:
                    begin
                        hi = sample_t'($urandom_range(1023));
                        lo = sample_t'($urandom_range(1023));
                    end
                    1:
                    begin
                        hi = (pass_i == 1) ? sample_t'(0) : SAMPLE_MAX;
                        lo = (pass_i == 1) ? SAMPLE_MAX : sample_t'(0);
                    end
                    default:
                    begin
                        hi = sample_t'($urandom_range(1023, 512));
                        lo = sample_t'($urandom_range(511));
                    end
                endcase
                write_reg(CFG_HIGH_THRESHOLD, hi);
                write_reg(CFG_LOW_THRESHOLD, lo);
                if (k == 0)
                    write_reg((pass_i == 1) ? CFG_SPARE_B : CFG_SPARE_A,
                              sample_t'($urandom_range(1023)));
                if (pass_i == 2 && k == 0)
                    hold_request++;
                repeat (RANDOM_WORDS)
                begin
                    draw_sample(s);
                    m = ($urandom_range(99) < 85);
                    send_word(s, m, 1'b0, '0);
                end
            end
        end

        // Let every result drain, then settle.
        sample_bus.valid <= 1'b0;
        while (light_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && light_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ moving_average_window_indicator.f @@
+incdir+hw/rtl
hw/rtl/mawi_pkg.sv
hw/rtl/mawi_in_if.sv
hw/rtl/mawi_out_if.sv
hw/rtl/mawi_cfg_if.sv
hw/rtl/mawi_cfg_regs.sv
hw/rtl/mawi_accum.sv
hw/rtl/mawi_result.sv
hw/rtl/moving_average_window_indicator.sv
tb/moving_average_window_indicator_tb.sv
